// ----- rtl/gsk_pkg.sv -----
package gsk_pkg;

  // Size of the key table and field widths.
  localparam int KEY_COUNT_DEF = 24;
  localparam int KEY_W         = 5;
  localparam int LEVEL_W       = 16;
  localparam int BTN_W         = 16;
  localparam int TRIG_W        = 8;
  localparam int COUNT_W       = 32;
  localparam int FLAGS_W       = 3;
  localparam int IN_W          = 32;
  localparam int OUT_W         = 144;

  // Keys with a fixed meaning outside the button and axis tables.
  localparam logic [KEY_W-1:0] KEY_LEFT_TRIG  = 5'd14;
  localparam logic [KEY_W-1:0] KEY_RIGHT_TRIG = 5'd15;

  // Axis codes.
  localparam logic [2:0] AXIS_LX   = 3'd0;
  localparam logic [2:0] AXIS_LY   = 3'd1;
  localparam logic [2:0] AXIS_RX   = 3'd2;
  localparam logic [2:0] AXIS_RY   = 3'd3;
  localparam logic [2:0] AXIS_NONE = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NOT_CONNECTED = 2'd1;
  localparam logic [1:0] ST_EMPTY         = 2'd2;

  typedef enum logic [1:0] {
    ACT_KEY    = 2'd0,
    ACT_STATE  = 2'd1,
    ACT_STROKE = 2'd2,
    ACT_VIBE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } ctl_t;

  // What the scan unit sees of the key at the current scan index.
  typedef struct packed {
    logic               down;
    logic               pending;
    logic [LEVEL_W-1:0] level;
  } key_view_t;

  // One result item, first field in the highest bits.
  typedef struct packed {
    logic [5:0]         pad;
    logic [FLAGS_W-1:0] event_flags;
    logic [KEY_W-1:0]   event_key;
    logic [LEVEL_W-1:0] right_y;
    logic [LEVEL_W-1:0] right_x;
    logic [LEVEL_W-1:0] left_y;
    logic [LEVEL_W-1:0] left_x;
    logic [TRIG_W-1:0]  right_trig;
    logic [TRIG_W-1:0]  left_trig;
    logic [BTN_W-1:0]   button_bits;
    logic [COUNT_W-1:0] packet_count;
    logic [1:0]         status;
  } result_t;

  // Button bit of each digital key; zero for keys that are not buttons.
  function automatic logic [BTN_W-1:0] btn_bit(input logic [KEY_W-1:0] k);
    logic [BTN_W-1:0] b;
    unique case (k)
      5'd0:    b = 16'h0004;  // dpad left
      5'd1:    b = 16'h0001;  // dpad up
      5'd2:    b = 16'h0008;  // dpad right
      5'd3:    b = 16'h0002;  // dpad down
      5'd4:    b = 16'h1000;  // A
      5'd5:    b = 16'h2000;  // B
      5'd6:    b = 16'h4000;  // X
      5'd7:    b = 16'h8000;  // Y
      5'd8:    b = 16'h0020;  // back
      5'd9:    b = 16'h0010;  // start
      5'd10:   b = 16'h0100;  // left shoulder
      5'd11:   b = 16'h0200;  // right shoulder
      5'd12:   b = 16'h0040;  // left thumb press
      5'd13:   b = 16'h0080;  // right thumb press
      default: b = '0;
    endcase
    return b;
  endfunction

  // Stick axis that each direction key drives.
  function automatic logic [2:0] axis_of(input logic [KEY_W-1:0] k);
    logic [2:0] a;
    unique case (k)
      5'd16, 5'd18: a = AXIS_LX;
      5'd17, 5'd19: a = AXIS_LY;
      5'd20, 5'd22: a = AXIS_RX;
      5'd21, 5'd23: a = AXIS_RY;
      default:      a = AXIS_NONE;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/gsk_ctrl.sv -----
module gsk_ctrl #(
  parameter int KEY_COUNT = gsk_pkg::KEY_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         need_scan,
  input  logic                         out_busy,
  output logic                         ready,
  output logic                         load,
  output gsk_pkg::ctl_t                ctl,
  output logic [$clog2(KEY_COUNT)-1:0] idx
);
  import gsk_pkg::*;

  localparam int IW = $clog2(KEY_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(KEY_COUNT - 1);

  state_t state, state_next;
  logic   last;

  assign last = (idx == LAST_IDX);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of each state.
  always_comb begin
    ready     = 1'b0;
    load      = 1'b0;
    ctl.clear = 1'b0;
    ctl.step  = 1'b0;
    unique case (state)
      S_IDLE:  begin
        ready     = 1'b1;
        ctl.clear = start;
      end
      S_SCAN:  ctl.step = 1'b1;
      S_DONE:  load = !out_busy;
      default: ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan index restarts with every item.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == S_SCAN) begin
      idx <= last ? '0 : idx + 1'b1;
    end else begin
      idx <= '0;
    end
  end

  // The scan index never runs past the last key.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= LAST_IDX))
    else $error("scan index out of range");

endmodule

// ----- rtl/gsk_scan.sv -----
module gsk_scan #(
  parameter int KEY_COUNT = gsk_pkg::KEY_COUNT_DEF
) (
  input  logic                                       clk,
  input  gsk_pkg::ctl_t                              ctl,
  input  logic                                       stroke_mode,
  input  logic [$clog2(KEY_COUNT)-1:0]               idx,
  input  gsk_pkg::key_view_t                         view,
  output logic [gsk_pkg::BTN_W-1:0]                  buttons,
  output logic                                       left_on,
  output logic                                       right_on,
  output logic [3:0][gsk_pkg::LEVEL_W-1:0]           axes,
  output logic [$clog2(KEY_COUNT)-1:0]               hi
);
  import gsk_pkg::*;

  logic [KEY_W-1:0] k;
  logic [2:0]       ax;

  assign k  = KEY_W'(idx);
  assign ax = axis_of(k);

  // One key per step: either fold a pressed key into the pad report or
  // remember the latest pending key. Later keys overwrite earlier ones.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      buttons  <= '0;
      left_on  <= 1'b0;
      right_on <= 1'b0;
      axes     <= '0;
      hi       <= '0;
    end else if (ctl.step) begin
      if (stroke_mode) begin
        if (view.pending) begin
          hi <= idx;
        end
      end else if (view.down) begin
        buttons <= buttons | btn_bit(k);
        if (k == KEY_LEFT_TRIG) begin
          left_on <= 1'b1;
        end
        if (k == KEY_RIGHT_TRIG) begin
          right_on <= 1'b1;
        end
        if (ax != AXIS_NONE) begin
          axes[ax[1:0]] <= view.level;
        end
      end
    end
  end

endmodule

// ----- rtl/gamepad_state_and_keystroke_events_core.sv -----
// Gamepad state and keystroke event core. Items arrive on s_* and each one
// yields exactly one result item on m_*. A key event (when active) updates
// one key entry and marks it pending; a state poll bumps the packet counter
// and reports buttons, triggers and stick axes; a keystroke poll reports the
// highest pending key with its down/up/repeat flags and clears all pending
// marks. Polls for a slot other than 0 report "not connected". Key events,
// vibration sets, other-slot polls, inactive polls and empty keystroke polls
// go from S_IDLE straight to S_DONE, where their result is loaded. State and
// keystroke polls that need the key table first pass through S_SCAN, where
// one shared scan unit steps through the table one key per cycle, then load
// their result in S_DONE. A new item is accepted only after the previous
// result is in the output register, which may still be waiting for m_tready;
// a waiting result blocks the load and holds the core in S_DONE. The user must
// write the active bit through cfg_we/cfg_wdata only while the core is idle;
// the core itself does not enforce this.
module gamepad_state_and_keystroke_events_core #(
  parameter int KEY_COUNT = gsk_pkg::KEY_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // action[1:0], user_slot[3:2], key_number[8:4], is_pressed[9],
  // axis_value[25:10], zero fill above.
  input  logic [gsk_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[1:0], packet_count[33:2], button_bits[49:34], left_trig[57:50],
  // right_trig[65:58], left_x[81:66], left_y[97:82], right_x[113:98],
  // right_y[129:114], event_key[134:130], event_flags[137:135], zero fill.
  output logic [gsk_pkg::OUT_W-1:0]  m_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata
);
  import gsk_pkg::*;

  localparam int IW = $clog2(KEY_COUNT);

  // Input fields.
  action_t            act;
  logic [1:0]         slot;
  logic [KEY_W-1:0]   key;
  logic               pressed;
  logic [LEVEL_W-1:0] level_in;

  assign act      = action_t'(s_tdata[1:0]);
  assign slot     = s_tdata[3:2];
  assign key      = s_tdata[8:4];
  assign pressed  = s_tdata[9];
  assign level_in = s_tdata[25:10];

  // Key table and counters.
  logic                              active;
  logic [KEY_COUNT-1:0]              key_down;
  logic [KEY_COUNT-1:0]              prior_down;
  logic [KEY_COUNT-1:0]              pending_mask;
  logic [KEY_COUNT-1:0][LEVEL_W-1:0] key_level;
  logic [COUNT_W-1:0]                poll_counter;

  // Latched item context.
  action_t act_q;
  logic    slot_bad_q;
  logic    empty_q;

  logic           accept;
  logic           need_scan;
  logic           key_write;
  logic           load;
  logic           out_busy;
  logic           stroke_clear;
  ctl_t           ctl;
  logic [IW-1:0]  idx;
  key_view_t      view;
  result_t        res;

  logic [BTN_W-1:0]          buttons;
  logic                      left_on;
  logic                      right_on;
  logic [3:0][LEVEL_W-1:0]   axes;
  logic [IW-1:0]             hi;

  assign accept    = s_tvalid && s_tready;
  assign out_busy  = m_tvalid && !m_tready;
  assign key_write = accept && (act == ACT_KEY) && active && (key < KEY_W'(KEY_COUNT));
  assign need_scan = (slot == 2'd0) && active &&
                     ((act == ACT_STATE) || ((act == ACT_STROKE) && (pending_mask != '0)));
  assign stroke_clear = load && (act_q == ACT_STROKE) && !slot_bad_q && !empty_q;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cfg_we) begin
      active <= cfg_wdata;
    end
  end

  // Key entries and pending marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_down     <= '0;
      prior_down   <= '0;
      pending_mask <= '0;
    end else if (key_write) begin
      prior_down[key[IW-1:0]]   <= key_down[key[IW-1:0]];
      key_down[key[IW-1:0]]     <= pressed;
      pending_mask[key[IW-1:0]] <= 1'b1;
    end else if (stroke_clear) begin
      pending_mask <= '0;
    end
  end

  // A level is only read while its key is pressed, which needs a prior write.
  always_ff @(posedge clk) begin
    if (key_write) begin
      key_level[key[IW-1:0]] <= level_in;
    end
  end

  // State poll counter counts every slot-0 poll, active or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_counter <= '0;
    end else if (accept && (act == ACT_STATE) && (slot == 2'd0)) begin
      poll_counter <= poll_counter + 1'b1;
    end
  end

  // Item context held until the result is loaded.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q      <= act;
      slot_bad_q <= (act != ACT_KEY) && (slot != 2'd0);
      empty_q    <= !active || (pending_mask == '0);
    end
  end

  gsk_ctrl #(.KEY_COUNT(KEY_COUNT)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .need_scan (need_scan),
    .out_busy  (out_busy),
    .ready     (s_tready),
    .load      (load),
    .ctl       (ctl),
    .idx       (idx)
  );

  assign view.down    = key_down[idx];
  assign view.pending = pending_mask[idx];
  assign view.level   = key_level[idx];

  gsk_scan #(.KEY_COUNT(KEY_COUNT)) u_scan (
    .clk         (clk),
    .ctl         (ctl),
    .stroke_mode (act_q == ACT_STROKE),
    .idx         (idx),
    .view        (view),
    .buttons     (buttons),
    .left_on     (left_on),
    .right_on    (right_on),
    .axes        (axes),
    .hi          (hi)
  );

  // Result assembly from the latched context and the scan unit.
  always_comb begin
    res = '0;
    if (slot_bad_q) begin
      res.status = ST_NOT_CONNECTED;
    end else begin
      unique case (act_q)
        ACT_STATE: begin
          res.status       = ST_OK;
          res.packet_count = poll_counter;
          res.button_bits  = buttons;
          res.left_trig    = {TRIG_W{left_on}};
          res.right_trig   = {TRIG_W{right_on}};
          res.left_x       = axes[AXIS_LX[1:0]];
          res.left_y       = axes[AXIS_LY[1:0]];
          res.right_x      = axes[AXIS_RX[1:0]];
          res.right_y      = axes[AXIS_RY[1:0]];
        end
        ACT_STROKE: begin
          if (empty_q) begin
            res.status = ST_EMPTY;
          end else begin
            res.status      = ST_OK;
            res.event_key   = KEY_W'(hi);
            res.event_flags = {prior_down[hi] == key_down[hi], !key_down[hi], key_down[hi]};
          end
        end
        ACT_KEY, ACT_VIBE: res.status = ST_OK;
        default:           res.status = ST_OK;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res;
    end
  end

  // A delivered keystroke event leaves nothing pending.
  assert property (@(posedge clk) disable iff (rst)
    stroke_clear |=> (pending_mask == '0))
    else $error("pending marks survived a keystroke report");

  // The packet counter only ever steps by one.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (poll_counter != $past(poll_counter))) |->
      (poll_counter == $past(poll_counter) + 1'b1))
    else $error("packet counter jumped");

  // No result carries an undefined status code.
  assert property (@(posedge clk) disable iff (rst)
    load |-> (res.status != 2'd3))
    else $error("undefined status code");

endmodule
